// ----- hw/rtl/pdc_pkg.sv -----
// ----------------------------------------------------------------------------
// pdc_pkg
// shared types and codes for the playfair digraph cipher core
// ----------------------------------------------------------------------------
package pdc_pkg;

    // action codes
    localparam logic [2:0] ACT_CLEAR   = 3'd0;
    localparam logic [2:0] ACT_KEY     = 3'd1;
    localparam logic [2:0] ACT_SEAL    = 3'd2;
    localparam logic [2:0] ACT_ENCRYPT = 3'd3;
    localparam logic [2:0] ACT_DECRYPT = 3'd4;

    // square geometry and letter indexes
    localparam int SQ_SIDE  = 5;
    localparam int SQ_CELLS = 25;
    localparam int LETTERS  = 26;

    localparam logic [4:0] IDX_I = 5'd8;
    localparam logic [4:0] IDX_J = 5'd9;
    localparam logic [4:0] IDX_X = 5'd23;

    localparam logic [2:0] SHIFT_ENC = 3'd1;
    localparam logic [2:0] SHIFT_DEC = 3'd4;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] char_in;
        logic       end_of_text;
    } item_t;

    typedef struct packed {
        logic [6:0] letter_out;
        logic       last_of_run;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic clear_key;
        logic place_key;
        logic seal_start;
        logic seal_step;
        logic pend_set;
        logic pend_clear;
        logic use_x;
        logic rd_place_a;
        logic rd_place_b;
        logic map_pair;
        logic rd_sq_a;
        logic rd_sq_b;
        logic emit_a;
        logic emit_b;
        logic emit_last;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] action;
        logic       is_letter;
        logic       pend_valid;
        logic       pend_match;
        logic       eot;
        logic       seal_last;
        logic       out_free;
    } status_t;

endpackage

// ----- hw/rtl/pdc_datapath.sv -----
// ----------------------------------------------------------------------------
// pdc_datapath
// key square storage, letter lookup, pair mapping and result register
// ----------------------------------------------------------------------------
module pdc_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  pdc_pkg::item_t    s_item,
    input  pdc_pkg::cmd_t     cmd,
    input  logic              m_ready,
    output pdc_pkg::status_t  status,
    output logic              m_valid,
    output pdc_pkg::result_t  m_result
);

    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CHR_UPPER_A = 8'h41;
    localparam logic [7:0] CHR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [6:0] OUT_BASE    = 7'h41;

    // byte to {valid, letter index}, j folded to i
    function automatic logic [5:0] norm_letter(input logic [7:0] c);
        logic [7:0] up;
        logic [4:0] idx;
        logic       ok;
        up  = (c >= CHR_LOWER_A && c <= CHR_LOWER_Z) ? c - CASE_OFFSET : c;
        ok  = (up >= CHR_UPPER_A) && (up <= CHR_UPPER_Z);
        idx = 5'(up - CHR_UPPER_A);
        if (idx == pdc_pkg::IDX_J) begin
            idx = pdc_pkg::IDX_I;
        end
        return {ok, idx};
    endfunction

    function automatic logic [2:0] row_of(input logic [4:0] p);
        logic [2:0] r;
        if (p < 5'd5) begin
            r = 3'd0;
        end else if (p < 5'd10) begin
            r = 3'd1;
        end else if (p < 5'd15) begin
            r = 3'd2;
        end else if (p < 5'd20) begin
            r = 3'd3;
        end else begin
            r = 3'd4;
        end
        return r;
    endfunction

    function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
        return 5'({r, 2'b00}) + 5'(r) + 5'(c);
    endfunction

    function automatic logic [2:0] col_of(input logic [4:0] p);
        logic [4:0] d;
        d = p - cell_of(row_of(p), 3'd0);
        return d[2:0];
    endfunction

    function automatic logic [2:0] add_mod5(input logic [2:0] v, input logic [2:0] sh);
        logic [3:0] s;
        s = 4'(v) + 4'(sh);
        if (s >= 4'(pdc_pkg::SQ_SIDE)) begin
            s = s - 4'(pdc_pkg::SQ_SIDE);
        end
        return s[2:0];
    endfunction

    // latched item
    logic [2:0] action_reg;
    logic [4:0] k_reg;
    logic       letter_reg;
    logic       eot_reg;

    // key state
    logic [4:0]                   pend_letter_reg;
    logic                         pend_valid_reg;
    logic [4:0]                   fill_reg;
    logic [pdc_pkg::LETTERS-1:0]  used_reg;
    logic [4:0]                   seal_idx_reg;

    logic [4:0] square_mem [pdc_pkg::SQ_CELLS];
    logic [4:0] place_mem  [pdc_pkg::LETTERS];

    logic [4:0] place_q_reg;
    logic [4:0] square_q_reg;
    logic [4:0] pa_reg;
    logic [4:0] oa_reg;
    logic [4:0] ob_reg;
    logic [4:0] res_a_reg;

    logic              m_valid_reg;
    pdc_pkg::result_t  m_data_reg;

    logic [5:0] norm_in;
    logic [4:0] place_idx;
    logic       place_cand;
    logic       place_en;
    logic [4:0] place_rd_addr;
    logic [4:0] sq_rd_addr;
    logic [2:0] shift;
    logic [2:0] ra, ca, rb, cb;
    logic [4:0] oa_next, ob_next;
    logic [4:0] emit_letter;

    assign norm_in = norm_letter(s_item.char_in);

    assign place_idx  = cmd.seal_step ? seal_idx_reg : k_reg;
    assign place_cand = cmd.seal_step ? (seal_idx_reg != pdc_pkg::IDX_J)
                                      : (cmd.place_key && letter_reg);
    assign place_en   = (cmd.seal_step || cmd.place_key) && place_cand
                        && !used_reg[place_idx]
                        && (fill_reg < 5'(pdc_pkg::SQ_CELLS));

    assign place_rd_addr = cmd.rd_place_a ? pend_letter_reg
                         : (cmd.use_x ? pdc_pkg::IDX_X : k_reg);
    assign sq_rd_addr    = cmd.rd_sq_a ? oa_reg : ob_reg;

    assign shift = (action_reg == pdc_pkg::ACT_ENCRYPT) ? pdc_pkg::SHIFT_ENC
                                                        : pdc_pkg::SHIFT_DEC;

    assign ra = row_of(pa_reg);
    assign ca = col_of(pa_reg);
    assign rb = row_of(place_q_reg);
    assign cb = col_of(place_q_reg);

    always_comb begin
        if (ra == rb) begin
            oa_next = cell_of(ra, add_mod5(ca, shift));
            ob_next = cell_of(rb, add_mod5(cb, shift));
        end else if (ca == cb) begin
            oa_next = cell_of(add_mod5(ra, shift), ca);
            ob_next = cell_of(add_mod5(rb, shift), cb);
        end else begin
            oa_next = cell_of(ra, cb);
            ob_next = cell_of(rb, ca);
        end
    end

    assign emit_letter = cmd.emit_a ? res_a_reg : square_q_reg;

    // item latch and pipeline payload
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            action_reg <= s_item.action;
            k_reg      <= norm_in[4:0];
            letter_reg <= norm_in[5];
            eot_reg    <= s_item.end_of_text;
        end
        if (cmd.rd_place_b) begin
            pa_reg <= place_q_reg;
        end
        if (cmd.map_pair) begin
            oa_reg <= oa_next;
            ob_reg <= ob_next;
        end
        if (cmd.rd_sq_b) begin
            res_a_reg <= square_q_reg;
        end
        if (cmd.emit_a || cmd.emit_b) begin
            m_data_reg.letter_out  <= OUT_BASE + {2'b00, emit_letter};
            m_data_reg.last_of_run <= cmd.emit_last;
        end
    end

    // memories
    always_ff @(posedge aclk) begin
        if (place_en) begin
            square_mem[fill_reg] <= place_idx;
            place_mem[place_idx] <= fill_reg;
        end
        if (cmd.rd_place_a || cmd.rd_place_b) begin
            place_q_reg <= place_mem[place_rd_addr];
        end
        if (cmd.rd_sq_a || cmd.rd_sq_b) begin
            square_q_reg <= square_mem[sq_rd_addr];
        end
    end

    // key and pending state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_letter_reg <= '0;
            pend_valid_reg  <= 1'b0;
            fill_reg        <= '0;
            used_reg        <= '0;
            seal_idx_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cmd.clear_key) begin
                pend_letter_reg <= '0;
                pend_valid_reg  <= 1'b0;
                fill_reg        <= '0;
                used_reg        <= '0;
            end else begin
                if (place_en) begin
                    used_reg[place_idx] <= 1'b1;
                    fill_reg            <= fill_reg + 5'd1;
                end
                if (cmd.pend_set) begin
                    pend_letter_reg <= k_reg;
                end
                if (cmd.pend_clear) begin
                    pend_valid_reg <= 1'b0;
                end else if (cmd.pend_set) begin
                    pend_valid_reg <= 1'b1;
                end
            end
            if (cmd.seal_start) begin
                seal_idx_reg <= '0;
            end else if (cmd.seal_step) begin
                seal_idx_reg <= seal_idx_reg + 5'd1;
            end
            if (cmd.emit_a || cmd.emit_b) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.action     = action_reg;
    assign status.is_letter  = letter_reg;
    assign status.pend_valid = pend_valid_reg;
    assign status.pend_match = (pend_letter_reg == k_reg);
    assign status.eot        = eot_reg;
    assign status.seal_last  = (seal_idx_reg == 5'(pdc_pkg::LETTERS - 1));
    assign status.out_free   = !m_valid_reg || m_ready;

    assign m_valid  = m_valid_reg;
    assign m_result = m_data_reg;

endmodule

// ----- hw/rtl/pdc_ctrl.sv -----
// ----------------------------------------------------------------------------
// pdc_ctrl
// sequencer for key building, sealing and pair mapping
// ----------------------------------------------------------------------------
module pdc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  pdc_pkg::status_t  status,
    output pdc_pkg::cmd_t     cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SEAL,
        ST_PA,
        ST_PB,
        ST_MAP,
        ST_SA,
        ST_SB,
        ST_EA,
        ST_EB
    } state_t;

    state_t     state_reg;
    logic [1:0] pairs_reg;
    logic       bx_reg;

    logic [1:0] dec_pairs;
    logic       dec_bx;
    logic       dec_set;
    logic       dec_clear;
    logic       is_text;

    assign is_text = (status.action == pdc_pkg::ACT_ENCRYPT)
                  || (status.action == pdc_pkg::ACT_DECRYPT);

    // pairing decision for a text byte
    always_comb begin
        dec_pairs = 2'd0;
        dec_bx    = 1'b1;
        dec_set   = 1'b0;
        dec_clear = 1'b0;
        if (status.action == pdc_pkg::ACT_ENCRYPT) begin
            if (status.is_letter && !status.pend_valid) begin
                dec_set   = 1'b1;
                dec_pairs = status.eot ? 2'd1 : 2'd0;
                dec_clear = status.eot;
            end else if (status.is_letter && status.pend_match) begin
                // doubled letter, split with x and keep it pending
                dec_pairs = status.eot ? 2'd2 : 2'd1;
                dec_clear = status.eot;
            end else if (status.is_letter) begin
                dec_pairs = 2'd1;
                dec_bx    = 1'b0;
                dec_clear = 1'b1;
            end else begin
                dec_pairs = (status.eot && status.pend_valid) ? 2'd1 : 2'd0;
                dec_clear = status.eot;
            end
        end else begin
            if (status.is_letter && !status.pend_valid) begin
                dec_set   = 1'b1;
                dec_clear = status.eot;
            end else if (status.is_letter) begin
                dec_pairs = 2'd1;
                dec_bx    = 1'b0;
                dec_clear = 1'b1;
            end else begin
                dec_clear = status.eot;
            end
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd            = '0;
        cmd.latch      = in_valid && (state_reg == ST_IDLE);
        cmd.clear_key  = (state_reg == ST_DISPATCH) && (status.action == pdc_pkg::ACT_CLEAR);
        cmd.place_key  = (state_reg == ST_DISPATCH) && (status.action == pdc_pkg::ACT_KEY);
        cmd.seal_start = (state_reg == ST_DISPATCH) && (status.action == pdc_pkg::ACT_SEAL);
        cmd.seal_step  = (state_reg == ST_SEAL);
        cmd.pend_set   = (state_reg == ST_DISPATCH) && is_text && dec_set;
        cmd.pend_clear = (state_reg == ST_DISPATCH) && is_text && dec_clear;
        cmd.use_x      = bx_reg;
        cmd.rd_place_a = (state_reg == ST_PA);
        cmd.rd_place_b = (state_reg == ST_PB);
        cmd.map_pair   = (state_reg == ST_MAP);
        cmd.rd_sq_a    = (state_reg == ST_SA);
        cmd.rd_sq_b    = (state_reg == ST_SB);
        cmd.emit_a     = (state_reg == ST_EA) && status.out_free;
        cmd.emit_b     = (state_reg == ST_EB) && status.out_free;
        cmd.emit_last  = (state_reg == ST_EB) && (pairs_reg == 2'd1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pairs_reg <= 2'd0;
            bx_reg    <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        state_reg <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH: begin
                    unique case (status.action)
                        pdc_pkg::ACT_SEAL: begin
                            state_reg <= ST_SEAL;
                        end
                        pdc_pkg::ACT_ENCRYPT, pdc_pkg::ACT_DECRYPT: begin
                            pairs_reg <= dec_pairs;
                            bx_reg    <= dec_bx;
                            state_reg <= (dec_pairs != 2'd0) ? ST_PA : ST_IDLE;
                        end
                        default: begin
                            state_reg <= ST_IDLE;
                        end
                    endcase
                end
                ST_SEAL: begin
                    if (status.seal_last) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_PA:  state_reg <= ST_PB;
                ST_PB:  state_reg <= ST_MAP;
                ST_MAP: state_reg <= ST_SA;
                ST_SA:  state_reg <= ST_SB;
                ST_SB:  state_reg <= ST_EA;
                ST_EA: begin
                    if (status.out_free) begin
                        state_reg <= ST_EB;
                    end
                end
                ST_EB: begin
                    if (status.out_free) begin
                        if (pairs_reg == 2'd1) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            // second pair is always the pending letter with x
                            pairs_reg <= pairs_reg - 2'd1;
                            bx_reg    <= 1'b1;
                            state_reg <= ST_PA;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/playfair_digraph_cipher_core.sv -----
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_core
// playfair cipher over a 5x5 keyed square, one byte per input transaction
// ----------------------------------------------------------------------------
// clear key and key byte: dispatch state, then idle and ready again
// seal: one letter visited per cycle over 26 letters, j and used ones skipped
// text byte: dispatch, then per pair the place reads, map, square reads and
// both emits, which wait out any output stall; each ram has one read port
// reset: controller idle, used flags, fill count and pending letter cleared;
// square and place rams hold no defined value until written by key building
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pdc_pkg::item_t    s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output pdc_pkg::result_t  m_result
);

    // command and status between sequencer and datapath
    pdc_pkg::cmd_t     cmd;
    pdc_pkg::status_t  status;

    // sequencer: takes one transaction, walks seal or pair lookup steps
    pdc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: square and place rams, mapping rules, result register
    // the result register lets the next byte in while a letter still waits
    pdc_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_item   (s_item),
        .cmd      (cmd),
        .m_ready  (m_ready),
        .status   (status),
        .m_valid  (m_valid),
        .m_result (m_result)
    );

    // an accepted byte always passes the dispatch state before the next one is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted on back to back cycles");

    // no result is loaded while the sequencer is idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !(cmd.emit_a || cmd.emit_b))
        else $error("result loaded while idle");

    // the first letter of a pair never closes a run
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_a |-> !cmd.emit_last)
        else $error("first letter of pair flagged as last");

endmodule
